/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the overlay slot allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OVB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("overlay allocator: same-cycle check failed");
`define OVB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("overlay allocator: next-cycle check failed");
`else
`define OVB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OVB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/ovbsa_pkg.sv */
// Shared types, constants and rounding helpers of the overlay slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package ovbsa_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int ROW_W      = 16;
    localparam int LINES_W    = 16;
    localparam int LIMIT_W    = 24;
    localparam int DIM_W      = 16;
    localparam int SLOT_PORT_W = 2;
    localparam int PITCH_W    = 19;
    localparam int RAW_W      = 35;
    localparam int END_W      = 36;
    localparam int NEXT_W     = 37;
    localparam int SUM_W      = 38;
    localparam int FRAME_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_BYTES = 2'd0,
        CFG_LINES     = 2'd1,
        CFG_LIMIT     = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_SLOT = 2'd1,
        STAT_NO_MEM  = 2'd2,
        STAT_BAD_REL = 2'd3
    } t_status;

    typedef struct packed {
        logic [ROW_W-1:0]   row_bytes;
        logic [LINES_W-1:0] lines;
        logic [LIMIT_W-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [END_W-1:0]  wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_ram_req;

    // width * bytes per pixel, rounded up to 16
    function automatic logic [PITCH_W-1:0] calc_pitch(input logic four,
                                                      input logic [DIM_W-1:0] w);
        logic [PITCH_W-1:0] wb;
        wb = four ? {1'b0, w, 2'b00} : {2'b00, w, 1'b0};
        return (wb + PITCH_W'(15)) & ~PITCH_W'(15);
    endfunction

    function automatic logic [END_W-1:0] round16(input logic [RAW_W-1:0] v);
        return (END_W'(v) + END_W'(15)) & ~END_W'(15);
    endfunction

    function automatic logic [NEXT_W-1:0] round_page(input logic [END_W-1:0] v);
        return (NEXT_W'(v) + NEXT_W'(4095)) & ~NEXT_W'(4095);
    endfunction

endpackage
`default_nettype wire

/* rtl/ovbsa_cfg_regs.sv */
// Configuration register file: frame geometry and overlay limit.
`timescale 1ns / 1ps
`default_nettype none
module ovbsa_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ovbsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ovbsa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ovbsa_pkg::t_cfg                       o_cfg
);
    import ovbsa_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROW_BYTES: r_cfg.row_bytes <= i_cfg_data[ROW_W-1:0];
                CFG_LINES:     r_cfg.lines     <= i_cfg_data[LINES_W-1:0];
                CFG_LIMIT:     r_cfg.limit     <= i_cfg_data[LIMIT_W-1:0];
                default: ; // unmapped index, ignored
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/ovbsa_end_ram.sv */
// Slot end table: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ovbsa_end_ram (
    input  wire logic                         i_clk,
    input  wire ovbsa_pkg::t_ram_req          i_req,
    output logic [ovbsa_pkg::END_W-1:0]       o_rdata
);
    import ovbsa_pkg::*;

    logic [END_W-1:0] mem [SLOT_COUNT];
    logic [END_W-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/overlay_buffer_slot_allocator_core.sv */
// Top level: request sequencer around the slot end table, one result per request.
// Sequence: an allocate runs the raw-size and frame multiplies, a slot table scan, a limit
//   check and a result state; a release, or an allocate with no free slot, skips to it.
// Throughput: one request at a time, taken again the cycle after the result is loaded; the
//   result waits while a stalled receiver still holds the previous one.
// Reset: synchronous active low; all slots free, state idle, no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module overlay_buffer_slot_allocator_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [ovbsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ovbsa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_func,
    input  wire logic                               i_four_byte_pixels,
    input  wire logic [ovbsa_pkg::DIM_W-1:0]        i_width_pixels,
    input  wire logic [ovbsa_pkg::DIM_W-1:0]        i_height_lines,
    input  wire logic [ovbsa_pkg::SLOT_PORT_W-1:0]  i_slot_index,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [1:0]                              o_status,
    output logic [ovbsa_pkg::SLOT_PORT_W-1:0]       o_slot,
    output logic [ovbsa_pkg::LIMIT_W-1:0]           o_offset,
    output logic [ovbsa_pkg::PITCH_W-1:0]           o_pitch
);
    import ovbsa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_MUL_RAW   = 6'b000010,
        S_MUL_FRAME = 6'b000100,
        S_SCAN      = 6'b001000,
        S_CHECK     = 6'b010000,
        S_FIN       = 6'b100000
    } t_state;

    t_cfg      cfg;
    t_ram_req  ram_req;
    logic [END_W-1:0] ram_rdata;

    t_state                r_state, n_state;
    logic [SLOT_COUNT-1:0] r_in_use, n_in_use;
    logic [DIM_W-1:0]      r_height;
    logic [PITCH_W-1:0]    r_pitch, n_pitch;
    logic [RAW_W-1:0]      r_raw, n_raw;
    logic [END_W-1:0]      r_size, n_size;
    logic [NEXT_W-1:0]     r_next, n_next;
    t_status               r_status, n_status;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_rd_vld, n_rd_vld;
    logic [SLOT_W-1:0]     r_rd_idx, n_rd_idx;
    // remembers whether the request in flight is an allocate
    logic                  r_alloc;

    // output register
    logic                   r_out_valid, n_out_valid;
    t_status                r_o_status, n_o_status;
    logic [SLOT_W-1:0]      r_o_slot, n_o_slot;
    logic [LIMIT_W-1:0]     r_o_offset, n_o_offset;
    logic [PITCH_W-1:0]     r_o_pitch, n_o_pitch;

    logic in_xfer;
    logic out_free;

    ovbsa_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ovbsa_end_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // requests enter only from idle; a result still waiting does not block this
    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    // output register can take a new result this cycle
    assign out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_slot      = SLOT_PORT_W'(r_o_slot);
    assign o_offset    = r_o_offset;
    assign o_pitch     = r_o_pitch;

    always_comb begin
        logic             found;
        logic [SLOT_W-1:0] free_idx;
        logic [FRAME_W-1:0] frame;
        logic [SLOT_W-1:0] rel_idx;

        n_state     = r_state;
        n_in_use    = r_in_use;
        n_pitch     = r_pitch;
        n_raw       = r_raw;
        n_size      = r_size;
        n_next      = r_next;
        n_status    = r_status;
        n_slot      = r_slot;
        n_cnt       = r_cnt;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_status  = r_o_status;
        n_o_slot    = r_o_slot;
        n_o_offset  = r_o_offset;
        n_o_pitch   = r_o_pitch;
        ram_req     = '0;
        found       = 1'b0;
        free_idx    = '0;
        frame       = '0;
        rel_idx     = SLOT_W'(i_slot_index);

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_func == FUNC_RELEASE) begin
                        // release is decided right here; the slot frees at once
                        if ((32'(i_slot_index) < SLOT_COUNT) && r_in_use[rel_idx]) begin
                            n_in_use[rel_idx] = 1'b0;
                            n_status          = STAT_OK;
                            n_slot            = rel_idx;
                        end else begin
                            n_status = STAT_BAD_REL;
                            n_slot   = '0;
                        end
                        n_next  = '0;
                        n_pitch = '0;
                        n_state = S_FIN;
                    end else begin
                        n_pitch = calc_pitch(i_four_byte_pixels, i_width_pixels);
                        n_state = S_MUL_RAW;
                    end
                end
            end
            S_MUL_RAW: begin
                n_raw = RAW_W'(r_pitch * r_height);
                // lowest free slot
                for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                    if (!r_in_use[i]) begin
                        found    = 1'b1;
                        free_idx = SLOT_W'(i);
                    end
                end
                n_slot = free_idx;
                if (found) begin
                    n_state = S_MUL_FRAME;
                end else begin
                    n_status = STAT_NO_SLOT;
                    n_next   = '0;
                    n_pitch  = '0;
                    n_state  = S_FIN;
                end
            end
            S_MUL_FRAME: begin
                frame   = cfg.row_bytes * cfg.lines;
                n_next  = round_page(END_W'(frame));
                n_size  = round16(r_raw);
                n_cnt   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // read slot r_cnt, judge the slot read in the cycle before
                if (32'(r_cnt) < SLOT_COUNT) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = r_cnt[SLOT_W-1:0];
                    n_rd_vld      = 1'b1;
                    n_rd_idx      = r_cnt[SLOT_W-1:0];
                    n_cnt         = r_cnt + CNT_W'(1);
                end else begin
                    n_state = S_CHECK;
                end
                if (r_rd_vld && r_in_use[r_rd_idx] && (NEXT_W'(ram_rdata) > r_next)) begin
                    n_next = round_page(ram_rdata);
                end
            end
            S_CHECK: begin
                if ((SUM_W'(r_next) + SUM_W'(r_size)) > SUM_W'(cfg.limit)) begin
                    n_status = STAT_NO_MEM;
                end else begin
                    n_status = STAT_OK;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_slot    = (r_status == STAT_OK) ? r_slot : '0;
                    n_o_offset  = (r_status == STAT_OK) ? r_next[LIMIT_W-1:0] : '0;
                    n_o_pitch   = (r_status == STAT_OK) ? r_pitch : '0;
                    // grant: mark the slot used and record where its buffer ends
                    if (r_status == STAT_OK && r_alloc) begin
                        n_in_use[r_slot] = 1'b1;
                        ram_req.we       = 1'b1;
                        ram_req.waddr    = r_slot;
                        ram_req.wdata    = END_W'(r_next + NEXT_W'(r_raw));
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_alloc     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_use    <= n_in_use;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= n_rd_vld;
            if (in_xfer) begin
                r_alloc <= (i_func == FUNC_ALLOC);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_height <= i_height_lines;
        end
        r_pitch    <= n_pitch;
        r_raw      <= n_raw;
        r_size     <= n_size;
        r_next     <= n_next;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_cnt      <= n_cnt;
        r_rd_idx   <= n_rd_idx;
        r_o_status <= n_o_status;
        r_o_slot   <= n_o_slot;
        r_o_offset <= n_o_offset;
        r_o_pitch  <= n_o_pitch;
    end

    // a taken request always leaves idle
    `OVB_ASSERT_NEXT(a_leave_idle, i_clk, i_rst_n, in_xfer, r_state != S_IDLE)
    // the end table is only written for a slot that was free
    `OVB_ASSERT_IMPL(a_write_free, i_clk, i_rst_n, ram_req.we, !r_in_use[ram_req.waddr])
    // failed requests carry no placement
    `OVB_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n,
                     o_out_valid && (o_status != STAT_OK), (o_offset == '0) && (o_pitch == '0))
    // a fresh result is never loaded over one still held by a stalled receiver
    `OVB_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n,
                     o_out_valid && i_out_stall && (r_state != S_FIN), o_out_valid)

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the overlay buffer slot allocator core.
`timescale 1ns / 1ps
module tb_top;
    import ovbsa_pkg::*;

    // ---------------------------------------------------------------------------------
    // Run shape
    // ---------------------------------------------------------------------------------
    localparam int PHASE_ITEMS    = 150;   // random requests per register setting
    localparam int RANDOM_PHASES  = 5;
    localparam int DRAIN_CYCLES   = 40;    // room for the last result to come out
    localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer on any channel
    localparam int REPORT_CAP     = 40;    // stop printing mismatches past this

    localparam logic [63:0] ROW_ALIGN  = 64'd15;
    localparam logic [63:0] PAGE_ALIGN = 64'd4095;
    localparam logic [63:0] END_MASK   = (64'd1 << END_W) - 64'd1;

    // index 3 has no register behind it; a write to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        t_func                  func;
        logic                   four;
        logic [DIM_W-1:0]       width;
        logic [DIM_W-1:0]       height;
        logic [SLOT_PORT_W-1:0] slot;
        logic                   wait_drain;  // hold off until all grants are back
    } t_req;

    typedef struct packed {
        t_status                status;
        logic [SLOT_PORT_W-1:0] slot;
        logic [LIMIT_W-1:0]     offset;
        logic [PITCH_W-1:0]     pitch;
    } t_grant;

    // ---------------------------------------------------------------------------------
    // Clock, reset and DUT
    // ---------------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic                   req_func  = 1'b0;
    logic                   req_four  = 1'b0;
    logic [DIM_W-1:0]       req_width = '0;
    logic [DIM_W-1:0]       req_height = '0;
    logic [SLOT_PORT_W-1:0] req_slot  = '0;

    logic                   res_valid;
    logic                   res_stall = 1'b0;
    logic [1:0]             res_status;
    logic [SLOT_PORT_W-1:0] res_slot;
    logic [LIMIT_W-1:0]     res_offset;
    logic [PITCH_W-1:0]     res_pitch;

    initial begin
        forever #5 clk = ~clk;
    end

    overlay_buffer_slot_allocator_core DUT (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (req_valid),
        .o_in_stall         (req_stall),
        .i_func             (req_func),
        .i_four_byte_pixels (req_four),
        .i_width_pixels     (req_width),
        .i_height_lines     (req_height),
        .i_slot_index       (req_slot),
        .o_out_valid        (res_valid),
        .i_out_stall        (res_stall),
        .o_status           (res_status),
        .o_slot             (res_slot),
        .o_offset           (res_offset),
        .o_pitch            (res_pitch)
    );

    // ---------------------------------------------------------------------------------
    // Shadow of the allocator: register copies and the slot table
    // ---------------------------------------------------------------------------------
    logic [ROW_W-1:0]   shadow_row   = '0;
    logic [LINES_W-1:0] shadow_lines = '0;
    logic [LIMIT_W-1:0] shadow_limit = '0;
    logic               slot_busy [SLOT_COUNT];
    logic [63:0]        slot_top  [SLOT_COUNT];  // offset + unrounded size, 36 bits

    t_req   req_q[$];    // requests not yet offered to the DUT
    t_grant grant_q[$];  // grants owed by the DUT, oldest first
    int     err_count = 0;

    function automatic logic [63:0] align_up(input logic [63:0] v, input logic [63:0] mask);
        return (v + mask) & ~mask;
    endfunction

    // Works out the grant for one request and updates the shadow table.
    // 64-bit math throughout, so the memory check never wraps.
    function automatic t_grant serve_request(input t_req r);
        t_grant      g;
        logic [63:0] pitch;
        logic [63:0] raw;
        logic [63:0] size;
        logic [63:0] next;
        int          free_slot;
        g = '{status: STAT_OK, slot: '0, offset: '0, pitch: '0};
        if (r.func == FUNC_RELEASE) begin
            if (slot_busy[r.slot]) begin
                slot_busy[r.slot] = 1'b0;
                g.slot = r.slot;
            end else begin
                g.status = STAT_BAD_REL;
            end
            return g;
        end
        pitch = align_up(64'(r.width) << (r.four ? 2 : 1), ROW_ALIGN);
        raw   = pitch * 64'(r.height);
        size  = align_up(raw, ROW_ALIGN);
        free_slot = -1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!slot_busy[i] && free_slot < 0) free_slot = i;
        end
        // slot exhaustion wins over the memory check
        if (free_slot < 0) begin
            g.status = STAT_NO_SLOT;
            return g;
        end
        // start past the frame, then past every used buffer that ends beyond that
        next = align_up(64'(shadow_row) * 64'(shadow_lines), PAGE_ALIGN);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_busy[i] && slot_top[i] > next) next = align_up(slot_top[i], PAGE_ALIGN);
        end
        if (next + size > 64'(shadow_limit)) begin
            g.status = STAT_NO_MEM;
            return g;
        end
        slot_busy[free_slot] = 1'b1;
        slot_top[free_slot]  = (next + raw) & END_MASK;
        g.slot   = SLOT_PORT_W'(free_slot);
        g.offset = next[LIMIT_W-1:0];
        g.pitch  = pitch[PITCH_W-1:0];
        return g;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (err_count < REPORT_CAP)
            $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        err_count++;
    endtask

    // ---------------------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps in between.
    // A request flagged wait_drain is held back until every grant is in.
    // ---------------------------------------------------------------------------------
    t_req cur_req;
    int   burst_left = 0;
    int   gap_left   = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && !req_stall) grant_q.push_back(serve_request(cur_req));
            if (!req_valid || !req_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_valid <= 1'b0;
                end else if (req_q.size() != 0 &&
                             !(req_q[0].wait_drain && grant_q.size() != 0)) begin
                    cur_req = req_q.pop_front();
                    req_func   <= cur_req.func;
                    req_four   <= cur_req.four;
                    req_width  <= cur_req.width;
                    req_height <= cur_req.height;
                    req_slot   <= cur_req.slot;
                    req_valid  <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        // a quarter of the bursts run straight into the next one
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Result monitor and stall pattern. The stall mode changes at random intervals:
    // never stall, light random stall, or heavy stall.
    // ---------------------------------------------------------------------------------
    int stall_mode = 0;
    int stall_span = 0;

    always @(posedge clk) begin : result_monitor
        t_grant want;
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (res_valid && !res_stall) begin
                if (grant_q.size() == 0) begin
                    flag_mismatch("result with no request outstanding, status",
                                  64'(res_status), 64'd0);
                end else begin
                    want = grant_q.pop_front();
                    if (res_status !== want.status)
                        flag_mismatch("status", 64'(res_status), 64'(want.status));
                    if (res_slot !== want.slot)
                        flag_mismatch("slot", 64'(res_slot), 64'(want.slot));
                    if (res_offset !== want.offset)
                        flag_mismatch("offset", 64'(res_offset), 64'(want.offset));
                    if (res_pitch !== want.pitch)
                        flag_mismatch("pitch", 64'(res_pitch), 64'(want.pitch));
                end
            end
            if (stall_span == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_span = $urandom_range(30, 200);
            end else begin
                stall_span--;
            end
            case (stall_mode)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 3) == 0);
                default: res_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Watchdog: ends the run when no channel has moved a transfer for too long
    // ---------------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------------
    function automatic t_req req_of(input t_func func, input int four,
                                    input int width, input int height, input int slot,
                                    input int wait_drain);
        t_req r;
        r.func       = func;
        r.four       = 1'(four);
        r.width      = DIM_W'(width);
        r.height     = DIM_W'(height);
        r.slot       = SLOT_PORT_W'(slot);
        r.wait_drain = 1'(wait_drain);
        return r;
    endfunction

    // Mostly small buffers so allocations keep landing; now and then full-range sizes.
    function automatic t_req make_request();
        t_req r;
        r.func = ($urandom_range(0, 9) < 6) ? FUNC_ALLOC : FUNC_RELEASE;
        r.four = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       r.width = DIM_W'($urandom);
            1:       r.width = '0;
            default: r.width = DIM_W'($urandom_range(1, 512));
        endcase
        case ($urandom_range(0, 7))
            0:       r.height = DIM_W'($urandom);
            1:       r.height = '0;
            default: r.height = DIM_W'($urandom_range(1, 256));
        endcase
        r.slot       = SLOT_PORT_W'($urandom_range(0, SLOT_COUNT - 1));
        r.wait_drain = ($urandom_range(0, 49) == 0);
        return r;
    endfunction

    // Blocks until the DUT has nothing in flight and nothing is queued for it.
    task automatic wait_quiet();
        while (req_q.size() != 0 || req_valid || grant_q.size() != 0) @(posedge clk);
    endtask

    // One register write; the shadow copy follows on the accepting edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ROW_BYTES: shadow_row   = val[ROW_W-1:0];
            CFG_LINES:     shadow_lines = val[LINES_W-1:0];
            CFG_LIMIT:     shadow_limit = val[LIMIT_W-1:0];
            default:       ;
        endcase
    endtask

    initial begin : stimulus
        logic [ROW_W-1:0]   row;
        logic [LINES_W-1:0] lines;
        logic [LIMIT_W-1:0] lim;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_busy[i] = 1'b0;
            slot_top[i]  = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, limit 0: only zero-size buffers fit.
        req_q.push_back(req_of(FUNC_RELEASE, 0, 0, 0, 0, 0));          // unused slots
        req_q.push_back(req_of(FUNC_RELEASE, 0, 0, 0, 3, 0));
        req_q.push_back(req_of(FUNC_ALLOC, 0, 0, 0, 0, 0));            // zero size at 0
        req_q.push_back(req_of(FUNC_ALLOC, 1, 1, 1, 0, 0));            // 16 bytes: no room
        req_q.push_back(req_of(FUNC_ALLOC, 1, 0, 65535, 0, 0));        // zero pitch, tall
        req_q.push_back(req_of(FUNC_RELEASE, 0, 0, 0, 1, 0));          // good release
        req_q.push_back(req_of(FUNC_RELEASE, 1, 65535, 65535, 1, 0));  // same slot again
        wait_quiet();

        // Frame ends exactly on a page; limit leaves room for one 256-byte buffer.
        write_reg(CFG_ROW_BYTES, 24'hAB1000);   // upper byte must be dropped
        write_reg(CFG_LINES, 24'h000001);
        write_reg(CFG_LIMIT, 24'd4352);
        req_q.push_back(req_of(FUNC_ALLOC, 0, 8, 16, 0, 0));           // exact fit
        req_q.push_back(req_of(FUNC_ALLOC, 0, 0, 0, 0, 0));            // pushed past limit
        req_q.push_back(req_of(FUNC_RELEASE, 0, 0, 0, 1, 0));
        req_q.push_back(req_of(FUNC_ALLOC, 0, 8, 16, 0, 0));           // same spot again
        wait_quiet();

        // Full limit: fill every slot, then hit slot exhaustion.
        write_reg(CFG_LIMIT, 24'hFFFFFF);
        write_reg(CFG_SPARE, 24'hFFFFFF);
        req_q.push_back(req_of(FUNC_ALLOC, 1, 65535, 0, 0, 0));        // widest pitch
        req_q.push_back(req_of(FUNC_ALLOC, 0, 65535, 65535, 0, 0));    // huge, no memory
        req_q.push_back(req_of(FUNC_ALLOC, 0, 1, 1, 0, 0));
        req_q.push_back(req_of(FUNC_ALLOC, 0, 1, 1, 0, 1));            // table full
        req_q.push_back(req_of(FUNC_ALLOC, 1, 65535, 65535, 0, 0));    // full beats no-mem
        req_q.push_back(req_of(FUNC_RELEASE, 0, 0, 0, 2, 0));
        req_q.push_back(req_of(FUNC_ALLOC, 1, 65535, 1, 0, 0));
        wait_quiet();

        // Random phases, one register setting each, the extremes among them.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    row   = ROW_W'($urandom_range(0, 8191));
                    lines = LINES_W'($urandom_range(0, 1023));
                    lim   = 24'hFFFFFF;
                end
                1: begin                 // frame alone exceeds any limit
                    row   = 16'hFFFF;
                    lines = 16'hFFFF;
                    lim   = 24'hFFFFFF;
                end
                2: begin
                    row   = '0;
                    lines = '0;
                    lim   = LIMIT_W'($urandom_range(24'h000400, 24'hFFFFFF));
                end
                3: begin                 // tight limit just past the frame
                    row   = ROW_W'($urandom_range(0, 1023));
                    lines = LINES_W'($urandom_range(0, 255));
                    lim   = LIMIT_W'(32'(row) * 32'(lines) + $urandom_range(0, 32'h100000));
                end
                default: begin
                    row   = ROW_W'($urandom);
                    lines = LINES_W'($urandom_range(0, 255));
                    lim   = LIMIT_W'($urandom);
                end
            endcase
            wait_quiet();
            write_reg(CFG_ROW_BYTES, {8'($urandom), row});
            write_reg(CFG_LINES, {8'($urandom), lines});
            write_reg(CFG_LIMIT, lim);
            repeat (PHASE_ITEMS) req_q.push_back(make_request());
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (grant_q.size() != 0)
            flag_mismatch("results never delivered", 64'(grant_q.size()), 64'd0);
        if (err_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
